@@ hw/rtl/ara_pkg.sv @@
package ara_pkg;
   localparam int TableEntries = 16;
   localparam int OwnerBits = 8;
   localparam int IdxBits = $clog2(TableEntries);
   localparam int CntBits = $clog2(TableEntries + 1);

   localparam logic [1:0] FUNC_RECORD = 2'd0;
   localparam logic [1:0] FUNC_ALLOC  = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FAIL    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_UNOWNED = 2'd3;

   localparam logic [0:0] REG_ALIGN_LOG2 = 1'd0;

   typedef struct packed {
      logic [OwnerBits-1:0] owner;
      logic [31:0]          last;
      logic [31:0]          first;
   } entry_type;
endpackage

@@ hw/rtl/ara_if.sv @@
interface ara_req_if;
   import ara_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic [31:0]          range_first;
   logic [31:0]          range_last;
   logic [31:0]          alloc_size;
   logic                 top_down;
   logic [OwnerBits-1:0] owner;
   logic [31:0]          lookup_address;
   modport source (output valid, func, range_first, range_last, alloc_size, top_down,
                   owner, lookup_address, input ready);
   modport sink (input valid, func, range_first, range_last, alloc_size, top_down,
                 owner, lookup_address, output ready);
endinterface

interface ara_rsp_if;
   import ara_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [31:0]          result_first;
   logic [31:0]          result_last;
   logic [OwnerBits-1:0] result_owner;
   modport source (output valid, status, result_first, result_last, result_owner,
                   input ready);
   modport sink (input valid, status, result_first, result_last, result_owner,
                 output ready);
endinterface

@@ hw/rtl/address_range_allocator_core.sv @@
// channel | dir | transfer
// req_    | in  | one request (record, allocate, lookup)
// rsp_    | out | one result per request
// csr_    | in  | apb write/read of align_log2
// steps: each table entry is read, then compared; a blocking entry in an allocation
// walk adds a further compare step. an insert searches again for its position, shifts
// the entries above it (read, then write each), then writes its entry and finishes.
// a reject goes straight to the finishing step. one request at a time.
// reset empties the table and sets align_log2 to 12; the memory needs no clearing.
// a result waits in its output register; no request is taken until it is transferred.
module address_range_allocator_core import ara_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ara_req_if.sink     req,
   ara_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:2]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_SHRD  = 3'd3;
   localparam logic [2:0] S_SHWR  = 3'd4;
   localparam logic [2:0] S_PUT   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // walk phases
   localparam logic [1:0] P_LOW  = 2'd0; // lower_idx search
   localparam logic [1:0] P_TOP  = 2'd1; // top-down stepping
   localparam logic [1:0] P_BOT  = 2'd2; // bottom-up stepping
   localparam logic [1:0] P_POS  = 2'd3; // insert position search

   entry_type mem [TableEntries];
   entry_type rd_q;
   logic [IdxBits-1:0] addr;
   logic wr_en;
   entry_type wr_data;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [CntBits-1:0] idx_ff, idx_in;
   logic [4:0]  align_ff;
   logic [1:0]  func_ff;
   logic        top_ff;
   logic [31:0] rf_ff, rl_ff, span_ff, laddr_ff;
   logic [OwnerBits-1:0] own_ff;
   logic [31:0] f_ff, f_in, l_ff, l_in;
   entry_type   carry_ff, carry_in;
   logic        rsp_valid_ff;
   logic [1:0]  st_ff, st_in;
   logic [31:0] of_ff, ol_ff;
   logic [OwnerBits-1:0] oo_ff;
   logic        fin;

   logic [31:0] mask, sz;
   assign mask = (32'd1 << align_ff) - 32'd1;
   assign sz = (req.alloc_size + mask) & ~mask;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_ALIGN_LOG2) ? {27'd0, align_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff <= 5'd12;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_ALIGN_LOG2) begin
         align_ff <= csr_pwdata[4:0];
      end
   end

   // entry memory, one port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_q <= mem[addr];
   end

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = st_ff;
   assign rsp.result_first = of_ff;
   assign rsp.result_last = ol_ff;
   assign rsp.result_owner = oo_ff;

   logic at_end;
   assign at_end = (idx_ff >= cnt_ff);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      f_in = f_ff;
      l_in = l_ff;
      carry_in = carry_ff;
      st_in = st_ff;
      fin = 1'b0;
      wr_en = 1'b0;
      wr_data = carry_ff;
      addr = idx_ff[IdxBits-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               idx_in = '0;
               phase_in = P_LOW;
               state_in = S_RD;
               f_in = req.range_first & ~mask;
               l_in = req.range_last | mask;
               if (req.func == FUNC_LOOKUP) begin
                  f_in = req.lookup_address;
               end else if (req.func == FUNC_RECORD || req.func == FUNC_ALLOC) begin
                  if (cnt_ff >= CntBits'(TableEntries)) begin
                     st_in = ST_FULL;
                     state_in = S_DONE;
                  end else if (req.func == FUNC_RECORD) begin
                     if (f_in > l_in) begin
                        st_in = ST_FAIL;
                        state_in = S_DONE;
                     end
                  end else if (req.range_first > req.range_last || sz == 32'd0 ||
                               (sz - 32'd1) > (req.range_last - req.range_first)) begin
                     st_in = ST_FAIL;
                     state_in = S_DONE;
                  end else if (req.top_down) begin
                     l_in = req.range_last;
                     f_in = req.range_last - (sz - 32'd1);
                  end else begin
                     f_in = req.range_first;
                     l_in = req.range_first + (sz - 32'd1);
                  end
               end else begin
                  st_in = ST_FAIL;
                  state_in = S_DONE;
               end
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_RD;
            case (phase_ff)
               P_LOW: begin
                  if (!at_end && rd_q.last < f_ff) begin
                     idx_in = idx_ff + 1'b1;
                  end else if (func_ff == FUNC_LOOKUP) begin
                     state_in = S_DONE;
                     if (at_end || laddr_ff < rd_q.first) begin
                        st_in = ST_UNOWNED;
                     end else begin
                        st_in = ST_OK;
                        f_in = rd_q.first;
                        l_in = rd_q.last;
                        carry_in.owner = rd_q.owner;
                     end
                  end else if (at_end || l_ff < rd_q.first) begin
                     phase_in = P_POS;
                     idx_in = '0;
                  end else if (func_ff == FUNC_RECORD) begin
                     st_in = ST_FAIL;
                     state_in = S_DONE;
                  end else begin
                     phase_in = top_ff ? P_TOP : P_BOT;
                     state_in = S_EVAL;
                  end
               end
               P_TOP: begin
                  // rd_q is entry idx, compared as blocking start
                  if (rd_q.first <= rf_ff + span_ff) begin
                     st_in = ST_FAIL;
                     state_in = S_DONE;
                  end else begin
                     l_in = rd_q.first - 32'd1;
                     f_in = rd_q.first - 32'd1 - span_ff;
                     if (idx_ff == '0) begin
                        phase_in = P_POS;
                     end else begin
                        idx_in = idx_ff - 1'b1;
                        phase_in = P_LOW;
                     end
                  end
               end
               P_BOT: begin
                  if (rd_q.last >= rl_ff - span_ff) begin
                     st_in = ST_FAIL;
                     state_in = S_DONE;
                  end else begin
                     f_in = rd_q.last + 32'd1;
                     l_in = rd_q.last + 32'd1 + span_ff;
                     idx_in = idx_ff + 1'b1;
                     // next entry: stop at the end or when it no longer blocks
                     phase_in = P_LOW;
                  end
               end
               default: begin // P_POS
                  if (!at_end && rd_q.first < f_ff) begin
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     carry_in.first = f_ff;
                     carry_in.last = l_ff;
                     carry_in.owner = own_ff;
                     idx_in = cnt_ff;
                     state_in = (cnt_ff == idx_ff) ? S_PUT : S_SHRD;
                     l_in = 32'(idx_ff); // insert position kept in l_ff low bits
                     f_in = f_ff;
                  end
               end
            endcase
         end
         S_SHRD: begin
            addr = IdxBits'(idx_ff - 1'b1);
            state_in = S_SHWR;
         end
         S_SHWR: begin
            wr_en = 1'b1;
            wr_data = rd_q;
            idx_in = idx_ff - 1'b1;
            state_in = (CntBits'(l_ff) == idx_ff - 1'b1) ? S_PUT : S_SHRD;
         end
         S_PUT: begin
            wr_en = 1'b1;
            wr_data = carry_ff;
            cnt_in = cnt_ff + 1'b1;
            st_in = ST_OK;
            f_in = carry_ff.first;
            l_in = carry_ff.last;
            state_in = S_DONE;
         end
         default: begin // S_DONE
            fin = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk registers and result register
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      idx_ff <= idx_in;
      f_ff <= f_in;
      l_ff <= l_in;
      carry_ff <= carry_in;
      st_ff <= st_in;
      if (req.valid && req.ready) begin
         func_ff <= req.func;
         top_ff <= req.top_down;
         rf_ff <= req.range_first;
         rl_ff <= req.range_last;
         span_ff <= sz - 32'd1;
         own_ff <= req.owner;
         laddr_ff <= req.lookup_address;
      end
      if (fin) begin
         if (st_ff == ST_OK) begin
            of_ff <= f_ff;
            ol_ff <= l_ff;
            oo_ff <= (func_ff == FUNC_LOOKUP) ? carry_ff.owner : own_ff;
         end else begin
            of_ff <= '0;
            ol_ff <= '0;
            oo_ff <= '0;
         end
      end
   end
endmodule
